// ===== src/mpm_pkg.sv =====
// Shared types and constants for the controller port and mailbox interface.
`timescale 1ns / 1ps
`default_nettype none

package mpm_pkg;

  typedef enum logic [2:0] {
    ActPortRead   = 3'd0,
    ActPortWrite  = 3'd1,
    ActDirWrite   = 3'd2,
    ActHostCmdWr  = 3'd3,
    ActHostDataRd = 3'd4,
    ActHostStatRd = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    PortA = 2'd0,
    PortB = 2'd1,
    PortC = 2'd2
  } port_e;

  localparam int unsigned NumPorts = 3;

  // Port B bit that fetches the host byte on a falling edge.
  localparam logic [7:0] FetchMask = 8'h02;
  // Port B bit that sends the port A byte on a rising edge.
  localparam logic [7:0] SendMask  = 8'h04;
  // Flag positions in port C pins and in the host status byte.
  localparam logic [7:0] FlagBit0  = 8'h01;
  localparam logic [7:0] FlagBit1  = 8'h02;

  localparam logic [7:0] PortBPinsReset = 8'hFF;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] port_sel;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       mcu_irq;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/mcu_port_mailbox_interface.sv =====
// Top level of the controller port and mailbox interface.
`timescale 1ns / 1ps
`default_nettype none

// This block models the three 8-bit ports of a small controller together with
// the two one-byte mailboxes that link it to a host. Every access is one input
// transfer carrying an action, a port select and a data byte, and it yields
// exactly one result transfer with the read byte and the controller interrupt
// level after the access. The register state is updated at the input transfer
// and the result lands in an output register that is shown on the next cycle.
// The input side stays ready while that register is empty or being drained, so
// unless the output stalls it takes one transfer per clock. The port B pin
// levels are a configuration register that resets to all ones and is written
// through cfg_we_i and cfg_wdata_i; the user must write it only while the
// block is idle, which the block itself does not enforce. Port A pins show the
// latched host byte, port C pins show the two mailbox flags, and a port B write
// detects the fetch and send edges against the old output latch.
module mcu_port_mailbox_interface (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [7:0]            cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  mpm_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output mpm_pkg::out_item_t   out_data_o
);
  import mpm_pkg::*;

  // Architectural state of the ports and mailboxes.
  logic [7:0] port_out_q [NumPorts];
  logic [7:0] port_out_d [NumPorts];
  logic [7:0] port_dir_q [NumPorts];
  logic [7:0] port_dir_d [NumPorts];
  logic [7:0] port_a_latch_q, port_a_latch_d;
  logic [7:0] host_to_mcu_q, host_to_mcu_d;
  logic [7:0] mcu_to_host_q, mcu_to_host_d;
  logic       host_sent_q, host_sent_d;
  logic       mcu_sent_q, mcu_sent_d;
  logic [7:0] port_b_pins_q;

  // Result register.
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic       accept;
  logic [7:0] pin_level;
  logic [7:0] read_byte;
  logic       port_ok;

  // The input side is free whenever the result register can take a new item.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign port_ok = (in_data_i.port_sel != 2'd3);

  // Pin levels seen on the addressed port.
  always_comb begin
    unique case (port_e'(in_data_i.port_sel))
      PortA:   pin_level = port_a_latch_q;
      PortB:   pin_level = port_b_pins_q;
      PortC: begin
        pin_level = 8'h00;
        if (host_sent_q) pin_level = pin_level | FlagBit0;
        if (!mcu_sent_q) pin_level = pin_level | FlagBit1;
      end
      default: pin_level = 8'h00;
    endcase
  end

  // Next state and result for the access at the input.
  always_comb begin
    port_out_d     = port_out_q;
    port_dir_d     = port_dir_q;
    port_a_latch_d = port_a_latch_q;
    host_to_mcu_d  = host_to_mcu_q;
    mcu_to_host_d  = mcu_to_host_q;
    host_sent_d    = host_sent_q;
    mcu_sent_d     = mcu_sent_q;
    read_byte      = 8'h00;

    unique case (action_e'(in_data_i.action))
      ActPortRead: begin
        if (port_ok) begin
          read_byte = (port_out_q[in_data_i.port_sel] & port_dir_q[in_data_i.port_sel]) |
                      (pin_level & ~port_dir_q[in_data_i.port_sel]);
        end
      end
      ActPortWrite: begin
        if (port_e'(in_data_i.port_sel) == PortB) begin
          // Edges are judged against the old latch, and only on output bits.
          if (((port_dir_q[PortB] & FetchMask) != 8'h00) &&
              ((in_data_i.data & FetchMask) == 8'h00) &&
              ((port_out_q[PortB] & FetchMask) != 8'h00)) begin
            port_a_latch_d = host_to_mcu_q;
            host_sent_d    = 1'b0;
          end
          if (((port_dir_q[PortB] & SendMask) != 8'h00) &&
              ((in_data_i.data & SendMask) != 8'h00) &&
              ((port_out_q[PortB] & SendMask) == 8'h00)) begin
            mcu_to_host_d = port_out_q[PortA];
            mcu_sent_d    = 1'b1;
          end
          port_out_d[PortB] = in_data_i.data;
        end else if (port_ok) begin
          port_out_d[in_data_i.port_sel] = in_data_i.data;
        end
      end
      ActDirWrite: begin
        if (port_ok) port_dir_d[in_data_i.port_sel] = in_data_i.data;
      end
      ActHostCmdWr: begin
        host_to_mcu_d = in_data_i.data;
        host_sent_d   = 1'b1;
      end
      ActHostDataRd: begin
        read_byte  = mcu_to_host_q;
        mcu_sent_d = 1'b0;
      end
      ActHostStatRd: begin
        if (!host_sent_q) read_byte = read_byte | FlagBit0;
        if (mcu_sent_q)   read_byte = read_byte | FlagBit1;
      end
      default: begin
      end
    endcase
  end

  // Result register load and drain.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      out_valid_d     = 1'b1;
      out_d.read_data = read_byte;
      out_d.mcu_irq   = host_sent_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPorts; i++) begin
        port_out_q[i] <= 8'h00;
        port_dir_q[i] <= 8'h00;
      end
      port_a_latch_q <= 8'h00;
      host_to_mcu_q  <= 8'h00;
      mcu_to_host_q  <= 8'h00;
      host_sent_q    <= 1'b0;
      mcu_sent_q     <= 1'b0;
      port_b_pins_q  <= PortBPinsReset;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        port_out_q     <= port_out_d;
        port_dir_q     <= port_dir_d;
        port_a_latch_q <= port_a_latch_d;
        host_to_mcu_q  <= host_to_mcu_d;
        mcu_to_host_q  <= mcu_to_host_d;
        host_sent_q    <= host_sent_d;
        mcu_sent_q     <= mcu_sent_d;
      end
      if (cfg_we_i) port_b_pins_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== src/mpm_checker.sv =====
// Port-level checks for the controller port and mailbox interface, with bind.
`timescale 1ns / 1ps
`default_nettype none

module mpm_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input mpm_pkg::in_item_t  in_data_i,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input mpm_pkg::out_item_t out_data_o
);
  import mpm_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // A stalled result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Every input transfer shows a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("input transfer produced no result");

  // A host command write always leaves the interrupt raised.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.action == ActHostCmdWr) |=> out_data_o.mcu_irq)
    else $error("host command did not raise interrupt");

  // Write actions return a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && ((in_data_i.action == ActPortWrite) || (in_data_i.action == ActDirWrite) ||
                (in_data_i.action == ActHostCmdWr))
    |=> out_data_o.read_data == 8'h00)
    else $error("write returned nonzero data");

endmodule

bind mcu_port_mailbox_interface mpm_checker u_mpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
